// ===== sv/i2c_slave_length_framed_buffer_core_macros.svh =====
// ---------------------------------------------------------------------------
// i2c slave buffer assertion macros
// concurrent assertion shorthands shared by the checker
// ---------------------------------------------------------------------------
`ifndef I2C_SLAVE_LENGTH_FRAMED_BUFFER_CORE_MACROS_SVH
`define I2C_SLAVE_LENGTH_FRAMED_BUFFER_CORE_MACROS_SVH

// same-cycle implication, masked while reset is applied
`define I2CSLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cslb checker: property violated");

// next-cycle implication, checked during reset too
`define I2CSLB_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("i2cslb checker: property violated");

`endif

// ===== sv/i2cslb_pkg.sv =====
// ---------------------------------------------------------------------------
// i2c slave buffer package
// status codes, field layout and shared types
// ---------------------------------------------------------------------------
`default_nettype none

package i2cslb_pkg;

  localparam int BUF_DEPTH_DEF = 512;

  // request kinds on in_tuser
  typedef enum logic [1:0] {
    REQ_BUS   = 2'd0,
    REQ_TX_WR = 2'd1,
    REQ_RX_RD = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // acknowledge control
  typedef enum logic [1:0] {
    ACK_KEEP  = 2'd0,
    ACK_SET   = 2'd1,
    ACK_CLEAR = 2'd2
  } ack_t;

  // slave status codes, low three bits already masked
  localparam logic [7:0] ST_SLA_W      = 8'h60;
  localparam logic [7:0] ST_GCALL      = 8'h70;
  localparam logic [7:0] ST_DATA_ACK   = 8'h80;
  localparam logic [7:0] ST_GDATA_ACK  = 8'h90;
  localparam logic [7:0] ST_DATA_NACK  = 8'h88;
  localparam logic [7:0] ST_GDATA_NACK = 8'h98;
  localparam logic [7:0] ST_STOP       = 8'hA0;
  localparam logic [7:0] ST_SLA_R      = 8'hA8;
  localparam logic [7:0] ST_TX_ACK     = 8'hB8;
  localparam logic [7:0] ST_TX_NACK    = 8'hC0;
  localparam logic [7:0] ST_IDLE       = 8'hF8;
  localparam logic [7:0] STATUS_MASK   = 8'hF8;

  // frame length is store byte 1 plus this header overhead
  localparam int LEN_OVERHEAD = 3;

  // field widths
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 9;

  // result word layout, lowest bit up
  localparam int OUT_ACK_LSB  = 0;
  localparam int OUT_CS_BIT   = 2;
  localparam int OUT_TXV_BIT  = 3;
  localparam int OUT_TXB_LSB  = 4;
  localparam int OUT_FD_BIT   = 12;
  localparam int OUT_OVF_BIT  = 13;
  localparam int OUT_RD_LSB   = 14;
  localparam int OUT_DATA_W   = 24;
  localparam int IN_DATA_W    = 40;

  // control outcome of one item, carried alongside the store read
  typedef struct packed {
    ack_t ack;
    logic clear_start;
    logic tx_valid;
    logic frame_done;
    logic overflow;
    logic sel_tx;
    logic sel_rx;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/i2c_slave_length_framed_buffer_core.sv =====
// ---------------------------------------------------------------------------
// i2c slave length-framed buffer core
// slave response logic with receive and transmit byte stores
// ---------------------------------------------------------------------------
// Takes one item per clock while in_tready is high and returns one result per
// item through the ram stage and then the result register. After reset both
// stores are zeroed by a sweep, one entry per cycle; in_tready stays low until
// it ends. The throughput is set by the two single-port store rams: each item
// makes at most one access to each store, issued at the accepting edge, and its
// read data lands in the next cycle ahead of the result register. Byte 1 of
// each store, which sets the frame length, is mirrored in a register so the
// length compare needs no extra ram port. An item that arrives while a result
// waits is still taken into the ram stage if that stage is empty.
`default_nettype none

module i2c_slave_length_framed_buffer_core
  import i2cslb_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input item
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // status_code[7:0], rx_byte[15:8], buf_index[24:16], buf_value[32:25]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]            in_tuser,
  // result item
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // ack_action[1:0], clear_start[2], tx_valid[3], tx_byte[11:4],
  // frame_done[12], overflow[13], read_data[21:14]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  // compare width: holds the count, an index and a length byte plus overhead
  localparam int IW = (CW > IDX_W + 1) ? CW : IDX_W + 1;

  // input fields
  req_t              req;
  logic [BYTE_W-1:0] code;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  buf_index;
  logic [BYTE_W-1:0] buf_value;
  logic              accept;

  assign req       = req_t'(in_tuser);
  assign code      = in_tdata[7:0] & STATUS_MASK;
  assign rx_byte   = in_tdata[15:8];
  assign buf_index = in_tdata[24:16];
  assign buf_value = in_tdata[32:25];
  assign accept    = in_tvalid && in_tready;

  // state
  logic [CW-1:0]     count_r, count_nxt;
  logic [BYTE_W-1:0] rx1_r, rx1_nxt;      // mirror of receive store byte 1
  logic [BYTE_W-1:0] tx1_r, tx1_nxt;      // mirror of transmit store byte 1
  logic              clearing_r;
  logic [AW-1:0]     clr_addr_r;

  // ram stage and result register
  logic              s1_valid_r;
  ctl_t              s1_ctl_r;
  ctl_t              ctl_dec;
  logic              s1_move;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // store ports
  logic              rx_en, rx_we, tx_en, tx_we;
  logic [AW-1:0]     rx_addr, tx_addr;
  logic [BYTE_W-1:0] rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  // decode helpers
  logic              rx_acc, rx_wr, tx_acc, tx_wr;
  logic [AW-1:0]     rx_dec_addr, tx_dec_addr;
  logic [IW-1:0]     cnt_w, idx_w, depth_w, cnt_new_w;
  logic              cnt_in, idx_in;
  logic [CW-1:0]     cnt_plus, cnt_rx;
  logic [BYTE_W-1:0] rx1_new;

  assign cnt_w    = IW'(count_r);
  assign idx_w    = IW'(buf_index);
  assign depth_w  = IW'(BUF_DEPTH);
  assign cnt_in   = cnt_w < depth_w;
  assign idx_in   = idx_w < depth_w;
  assign cnt_plus = count_r + CW'(1);
  // count after a received byte, saturating at the depth
  assign cnt_rx   = cnt_in ? cnt_plus : count_r;
  assign cnt_new_w = IW'(cnt_rx);
  // a byte landing at entry 1 declares the length it is compared with
  assign rx1_new  = (cnt_in && (count_r == CW'(1))) ? rx_byte : rx1_r;

  // per-item decode
  always_comb begin
    ctl_dec     = '0;
    count_nxt   = count_r;
    rx1_nxt     = rx1_r;
    tx1_nxt     = tx1_r;
    rx_acc      = 1'b0;
    rx_wr       = 1'b0;
    tx_acc      = 1'b0;
    tx_wr       = 1'b0;
    rx_dec_addr = count_r[AW-1:0];
    tx_dec_addr = idx_w[AW-1:0];
    unique case (req)
      REQ_BUS: begin
        unique case (code)
          ST_IDLE, ST_DATA_NACK, ST_GDATA_NACK: begin
          end
          ST_SLA_W, ST_GCALL: begin
            count_nxt   = '0;
            ctl_dec.ack = ACK_SET;
          end
          ST_DATA_ACK, ST_GDATA_ACK: begin
            if (cnt_in) begin
              rx_acc = 1'b1;
              rx_wr  = 1'b1;
            end else begin
              ctl_dec.overflow = 1'b1;
            end
            count_nxt = cnt_rx;
            rx1_nxt   = rx1_new;
            if (cnt_new_w == IW'(rx1_new) + IW'(LEN_OVERHEAD)) begin
              ctl_dec.ack        = ACK_CLEAR;
              ctl_dec.frame_done = 1'b1;
            end else begin
              ctl_dec.ack = ACK_SET;
            end
          end
          ST_STOP: begin
            ctl_dec.ack = ACK_SET;
          end
          ST_SLA_R: begin
            count_nxt        = CW'(1);
            tx_acc           = 1'b1;
            tx_dec_addr      = '0;
            ctl_dec.tx_valid = 1'b1;
            ctl_dec.sel_tx   = 1'b1;
            ctl_dec.ack      = ACK_SET;
          end
          ST_TX_ACK: begin
            ctl_dec.tx_valid = 1'b1;
            tx_dec_addr      = count_r[AW-1:0];
            if (cnt_in) begin
              tx_acc         = 1'b1;
              ctl_dec.sel_tx = 1'b1;
            end else begin
              ctl_dec.overflow = 1'b1;
            end
            // last byte of the declared length withdraws acknowledge
            if (cnt_w < IW'(tx1_r) + IW'(LEN_OVERHEAD)) begin
              count_nxt   = cnt_rx;
              ctl_dec.ack = ACK_SET;
            end else begin
              ctl_dec.ack = ACK_CLEAR;
            end
          end
          ST_TX_NACK: begin
            ctl_dec.ack         = ACK_SET;
            ctl_dec.clear_start = 1'b1;
          end
          default: begin
            ctl_dec.clear_start = 1'b1;
          end
        endcase
      end
      REQ_TX_WR: begin
        if (idx_in) begin
          tx_acc = 1'b1;
          tx_wr  = 1'b1;
          if (idx_w == IW'(1)) begin
            tx1_nxt = buf_value;
          end
        end else begin
          ctl_dec.overflow = 1'b1;
        end
      end
      REQ_RX_RD: begin
        rx_dec_addr = idx_w[AW-1:0];
        if (idx_in) begin
          rx_acc         = 1'b1;
          ctl_dec.sel_rx = 1'b1;
        end else begin
          ctl_dec.overflow = 1'b1;
        end
      end
      REQ_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // store port muxing: the clearing sweep owns both rams after reset
  always_comb begin
    if (clearing_r) begin
      rx_en    = 1'b1;
      rx_we    = 1'b1;
      rx_addr  = clr_addr_r;
      rx_wdata = '0;
      tx_en    = 1'b1;
      tx_we    = 1'b1;
      tx_addr  = clr_addr_r;
      tx_wdata = '0;
    end else begin
      rx_en    = accept && rx_acc;
      rx_we    = rx_wr;
      rx_addr  = rx_dec_addr;
      rx_wdata = rx_byte;
      tx_en    = accept && tx_acc;
      tx_we    = tx_wr;
      tx_addr  = tx_dec_addr;
      tx_wdata = buf_value;
    end
  end

  i2cslb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .en      (rx_en),
    .we      (rx_we),
    .addr    (rx_addr),
    .wr_data (rx_wdata),
    .rd_data (rx_rdata)
  );

  i2cslb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_tx_ram (
    .clk     (clk),
    .en      (tx_en),
    .we      (tx_we),
    .addr    (tx_addr),
    .wr_data (tx_wdata),
    .rd_data (tx_rdata)
  );

  // ram stage moves on when the result register is free or being emptied
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || !out_valid_r || out_tready);

  // result word, fields that do not apply stay zero
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_ACK_LSB +: 2]      = s1_ctl_r.ack;
    out_data_nxt[OUT_CS_BIT]            = s1_ctl_r.clear_start;
    out_data_nxt[OUT_TXV_BIT]           = s1_ctl_r.tx_valid;
    out_data_nxt[OUT_TXB_LSB +: BYTE_W] = s1_ctl_r.sel_tx ? tx_rdata : '0;
    out_data_nxt[OUT_FD_BIT]            = s1_ctl_r.frame_done;
    out_data_nxt[OUT_OVF_BIT]           = s1_ctl_r.overflow;
    out_data_nxt[OUT_RD_LSB +: BYTE_W]  = s1_ctl_r.sel_rx ? rx_rdata : '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rx1_r       <= '0;
      tx1_r       <= '0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(BUF_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        count_r <= count_nxt;
        rx1_r   <= rx1_nxt;
        tx1_r   <= tx1_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl_dec;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/i2cslb_ram.sv =====
// ---------------------------------------------------------------------------
// i2c slave buffer store ram
// single-port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module i2cslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wr_data;
      end else begin
        rd_data_r <= mem_r[addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/i2cslb_checker.sv =====
// ---------------------------------------------------------------------------
// i2c slave buffer checker
// port-level properties of the result stream
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_slave_length_framed_buffer_core_macros.svh"

module i2cslb_checker
  import i2cslb_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  logic [1:0]        ack;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              frame_done;
  logic [BYTE_W-1:0] read_data;

  assign ack        = out_tdata[OUT_ACK_LSB +: 2];
  assign tx_valid   = out_tdata[OUT_TXV_BIT];
  assign tx_byte    = out_tdata[OUT_TXB_LSB +: BYTE_W];
  assign frame_done = out_tdata[OUT_FD_BIT];
  assign read_data  = out_tdata[OUT_RD_LSB +: BYTE_W];

  // nothing is offered right after reset
  `I2CSLB_ASSERT_NXT(a_reset_empty, clk, !rst_n, !out_tvalid)

  // a byte to send only appears with its load strobe
  `I2CSLB_ASSERT_IMP(a_txbyte_strobe, clk, rst_n, out_tvalid && !tx_valid, tx_byte == '0)

  // a finished frame always withdraws acknowledge
  `I2CSLB_ASSERT_IMP(a_frame_nack, clk, rst_n, out_tvalid && frame_done,
                     ack == ACK_CLEAR)

  // software read data never mixes with bus responses
  `I2CSLB_ASSERT_IMP(a_read_alone, clk, rst_n, out_tvalid && (read_data != '0),
                     (ack == ACK_KEEP) && !tx_valid && !frame_done)

endmodule

bind i2c_slave_length_framed_buffer_core i2cslb_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tdata  (out_tdata)
);

`default_nettype wire
